// File: design/gcd_pkg.sv
// Shared constants, types and functions for the great-circle distance pipeline.
package gcd_pkg;

  localparam int CORDIC_STEPS_DEF = 20;
  localparam int RADIUS_W = 13;
  localparam int DIST_W = 19;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd3959;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
  localparam logic signed [27:0] FULL_TURN = 28'sd47185920;
  localparam logic signed [27:0] HALF_TURN = 28'sd23592960;
  localparam logic signed [27:0] QUARTER_TURN = 28'sd11796480;
  localparam logic [30:0] DEG_TO_RAD = 31'd1199381129;
  localparam logic [DIST_W-1:0] DIST_MAX = 19'd524287;

  // CORDIC datapath: x and y in Q30 with headroom, z in Q30 radians
  typedef logic signed [33:0] cval_t;

  function automatic cval_t atan_at(input int i);
    cval_t t;
    t = '0;
    unique case (i)
      0: t = 34'sd843314857;
      1: t = 34'sd497837829;
      2: t = 34'sd263043837;
      3: t = 34'sd133525159;
      4: t = 34'sd67021687;
      5: t = 34'sd33543516;
      6: t = 34'sd16775851;
      7: t = 34'sd8388437;
      8: t = 34'sd4194283;
      9: t = 34'sd2097149;
      default: begin
        if (i < 31) t = cval_t'(64'sd1 <<< (30 - i));
        else t = '0;
      end
    endcase
    return t;
  endfunction

endpackage

// File: design/great_circle_distance.sv
// Top level of the haversine great-circle distance pipeline.
// Usage: drive the four coordinates with start high; busy is never raised, so a
// transaction is taken in every cycle that start is high. Each result appears on
// out_arc_distance for one cycle with out_valid high, after passing through the
// differences, trig, products, sum and clamp, square root, atan2 and final
// scale, round and saturate stages in that order. Throughput is one transaction
// per cycle, set by the fully unrolled CORDIC and square-root stages.
// The sphere radius is written through cfg_valid/cfg_ready (always ready), and
// takes effect for transactions reaching the scaling multiply after the write;
// write it only when the pipeline is empty. Reset (rst_n low, synchronous) clears
// the valid bits of every stage and loads the radius 3959. The receiver cannot
// stall, so there is no back-pressure path.
module great_circle_distance #(
  parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [23:0]                 in_first_latitude,
  input  logic signed [24:0]                 in_first_longitude,
  input  logic signed [23:0]                 in_second_latitude,
  input  logic signed [24:0]                 in_second_longitude,
  output logic                               out_valid,
  output logic [gcd_pkg::DIST_W-1:0]         out_arc_distance,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gcd_pkg::RADIUS_W-1:0]       cfg_sphere_radius
);

  localparam int LAT = 2 * CORDIC_STEPS + 47;

  logic [gcd_pkg::RADIUS_W-1:0] radius_r;
  logic [LAT-1:0] vld_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gcd_pkg::RADIUS_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_valid) radius_r <= cfg_sphere_radius;
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // stage 1-2: angle arguments
  logic signed [27:0] a1_r, a2_r, a3_r, a4_r, b1_r, b2_r, b3_r, b4_r;
  always_ff @(posedge clk) begin
    a1_r <= 28'(in_first_latitude) <<< 1;
    a2_r <= 28'(in_second_latitude) <<< 1;
    a3_r <= 28'(in_second_latitude) - 28'(in_first_latitude);
    a4_r <= 28'(in_second_longitude) - 28'(in_first_longitude);
    b1_r <= a1_r; b2_r <= a2_r; b3_r <= a3_r; b4_r <= a4_r;
  end

  logic signed [33:0] s1, c1, s2, c2, sl, cl, so, co;
  gcd_trig #(.STEPS(CORDIC_STEPS)) u_t1 (.clk, .in_angle(b1_r), .out_sin(s1), .out_cos(c1));
  gcd_trig #(.STEPS(CORDIC_STEPS)) u_t2 (.clk, .in_angle(b2_r), .out_sin(s2), .out_cos(c2));
  gcd_trig #(.STEPS(CORDIC_STEPS)) u_t3 (.clk, .in_angle(b3_r), .out_sin(sl), .out_cos(cl));
  gcd_trig #(.STEPS(CORDIC_STEPS)) u_t4 (.clk, .in_angle(b4_r), .out_sin(so), .out_cos(co));

  // products: squares and cosine product, then the cross term
  logic signed [31:0] hl_r, ho_r, cc_r;
  logic signed [63:0] psl_r, pso_r, pcc_r, px_r;
  logic signed [31:0] hl1_r;
  always_ff @(posedge clk) begin
    psl_r <= 64'(sl) * 64'(sl);
    pso_r <= 64'(so) * 64'(so);
    pcc_r <= 64'(c1) * 64'(c2);
    hl_r <= 32'(psl_r >>> 30);
    ho_r <= 32'(pso_r >>> 30);
    cc_r <= 32'(pcc_r >>> 30);
    hl1_r <= hl_r;
    px_r <= 64'(cc_r) * 64'(ho_r);
  end

  logic signed [33:0] asum_r;
  logic [30:0] a_r;
  logic signed [33:0] asum;
  assign asum = 34'(hl1_r) + 34'(px_r >>> 30);
  always_ff @(posedge clk) begin
    asum_r <= asum;
    if (asum_r < 0) a_r <= '0;
    else if (asum_r > gcd_pkg::ONE_Q30) a_r <= 31'(gcd_pkg::ONE_Q30);
    else a_r <= asum_r[30:0];
  end

  logic [30:0] ry, rx;
  logic [30:0] na;
  assign na = 31'(gcd_pkg::ONE_Q30) - a_r;
  gcd_sqrt u_sy (.clk, .in_val({a_r, 30'd0}), .out_root(ry));
  gcd_sqrt u_sx (.clk, .in_val({na, 30'd0}), .out_root(rx));

  // vectoring CORDIC for atan2
  gcd_pkg::cval_t vx_r [CORDIC_STEPS+1];
  gcd_pkg::cval_t vy_r [CORDIC_STEPS+1];
  gcd_pkg::cval_t vz_r [CORDIC_STEPS+1];
  always_ff @(posedge clk) begin
    vx_r[0] <= 34'(rx);
    vy_r[0] <= 34'(ry);
    vz_r[0] <= '0;
  end
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (vy_r[i] > 0) begin
        vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] + gcd_pkg::atan_at(i);
      end else begin
        vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] - gcd_pkg::atan_at(i);
      end
    end
  end

  logic [30:0] z_r;
  logic [44:0] d_r;
  logic [gcd_pkg::DIST_W-1:0] dist_r;
  logic [44:0] dr;
  gcd_pkg::cval_t zf;
  assign zf = vz_r[CORDIC_STEPS];
  assign dr = d_r + 45'(25'd16777216);
  always_ff @(posedge clk) begin
    z_r <= (zf < 0) ? '0 : zf[30:0];
    d_r <= 45'(radius_r) * 45'(z_r);
    if (dr[44:25] > 20'(gcd_pkg::DIST_MAX)) dist_r <= gcd_pkg::DIST_MAX;
    else dist_r <= dr[43:25];
  end
  assign out_arc_distance = dist_r;

  a_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> $past(start)) else $error("valid without start");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_arc_distance <= gcd_pkg::DIST_MAX) else $error("range");

endmodule

// File: design/gcd_trig.sv
// Pipelined rotation CORDIC: reduced angle in 2^-17 degree to |sin| and cos, Q30.
module gcd_trig #(
  parameter int STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic signed [27:0]  in_angle,
  output logic signed [33:0]  out_sin,
  output logic signed [33:0]  out_cos
);

  logic signed [27:0] m0_r;
  logic        [24:0] m1_r;
  logic               neg1_r;
  logic        [55:0] prod_r;
  logic               neg2_r;
  gcd_pkg::cval_t     xs_r [STEPS+1];
  gcd_pkg::cval_t     ys_r [STEPS+1];
  gcd_pkg::cval_t     zs_r [STEPS+1];
  logic               ng_r [STEPS+1];
  logic signed [27:0] mod_nxt;
  logic signed [27:0] fold_nxt;
  logic               neg_nxt;

  // reduce modulo a full turn: one subtraction and two additions cover inputs from -2 to just under +2 turns
  always_comb begin
    mod_nxt = in_angle;
    if (mod_nxt >= gcd_pkg::FULL_TURN) mod_nxt = mod_nxt - gcd_pkg::FULL_TURN;
    if (mod_nxt < 0) mod_nxt = mod_nxt + gcd_pkg::FULL_TURN;
    if (mod_nxt < 0) mod_nxt = mod_nxt + gcd_pkg::FULL_TURN;
  end

  always_comb begin
    fold_nxt = m0_r;
    neg_nxt = 1'b0;
    if (fold_nxt > gcd_pkg::HALF_TURN) fold_nxt = gcd_pkg::FULL_TURN - fold_nxt;
    if (fold_nxt > gcd_pkg::QUARTER_TURN) begin
      fold_nxt = gcd_pkg::HALF_TURN - fold_nxt;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    m0_r <= mod_nxt;
    m1_r <= fold_nxt[24:0];
    neg1_r <= neg_nxt;
    prod_r <= m1_r * gcd_pkg::DEG_TO_RAD;
    neg2_r <= neg1_r;
    xs_r[0] <= gcd_pkg::INV_GAIN;
    ys_r[0] <= '0;
    zs_r[0] <= gcd_pkg::cval_t'(prod_r[55:23]);
    ng_r[0] <= neg2_r;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (zs_r[i] >= 0) begin
        xs_r[i+1] <= xs_r[i] - (ys_r[i] >>> i);
        ys_r[i+1] <= ys_r[i] + (xs_r[i] >>> i);
        zs_r[i+1] <= zs_r[i] - gcd_pkg::atan_at(i);
      end else begin
        xs_r[i+1] <= xs_r[i] + (ys_r[i] >>> i);
        ys_r[i+1] <= ys_r[i] - (xs_r[i] >>> i);
        zs_r[i+1] <= zs_r[i] + gcd_pkg::atan_at(i);
      end
      ng_r[i+1] <= ng_r[i];
    end
  end

  function automatic gcd_pkg::cval_t clamp1(input gcd_pkg::cval_t v);
    if (v > gcd_pkg::ONE_Q30) return gcd_pkg::ONE_Q30;
    if (v < -gcd_pkg::ONE_Q30) return -gcd_pkg::ONE_Q30;
    return v;
  endfunction

  gcd_pkg::cval_t cx;
  assign cx = clamp1(xs_r[STEPS]);
  assign out_sin = clamp1(ys_r[STEPS]);
  assign out_cos = ng_r[STEPS] ? -cx : cx;

endmodule

// File: design/gcd_sqrt.sv
// Pipelined restoring integer square root of a 61-bit value, one result bit a stage.
module gcd_sqrt (
  input  logic        clk,
  input  logic [60:0] in_val,
  output logic [30:0] out_root
);

  localparam int NB = 31;

  logic [61:0] rem_r  [NB+1];
  logic [30:0] root_r [NB+1];
  logic [61:0] src_r  [NB+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    root_r[0] <= '0;
    src_r[0] <= {1'b0, in_val};
  end

  // one bit per stage: bring down two source bits, try root*4+1
  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int B = NB - 1 - k;
    logic [63:0] trial;
    logic [63:0] cand;
    assign trial = {rem_r[k], src_r[k][2*B+1 -: 2]};
    assign cand = {31'd0, root_r[k], 2'b01};
    always_ff @(posedge clk) begin
      src_r[k+1] <= src_r[k];
      if (trial >= cand) begin
        rem_r[k+1] <= 62'(trial - cand);
        root_r[k+1] <= {root_r[k][29:0], 1'b1};
      end else begin
        rem_r[k+1] <= trial[61:0];
        root_r[k+1] <= {root_r[k][29:0], 1'b0};
      end
    end
  end

  assign out_root = root_r[NB];

endmodule
